>>> hw/rtl/spfs_pkg.sv
// ----------------------------------------------------------------------------
// spfs_pkg
// shared types and codes for the strict priority fifo scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spfs_pkg;

    localparam int THREAD_ID_W = 8;
    localparam int PRIO_W      = 2;
    localparam int KIND_W      = 2;
    localparam int ID_MAX_W    = 16;

    localparam logic REQ_CREATE   = 1'b0;
    localparam logic REQ_SCHEDULE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_KEEP = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SWAP = 2'd1;
    localparam logic [KIND_W-1:0] KIND_SET  = 2'd2;

    typedef struct packed {
        logic                   req_type;
        logic [THREAD_ID_W-1:0] thread_id;
        logic [PRIO_W-1:0]      thread_prio;
        logic                   current_valid;
    } spfs_in_t;

    typedef struct packed {
        logic                   next_valid;
        logic [THREAD_ID_W-1:0] next_id;
        logic [KIND_W-1:0]      switch_kind;
        logic                   overflow;
    } spfs_out_t;

    typedef struct packed {
        logic              push_en;
        logic              pop_en;
        logic [PRIO_W-1:0] push_prio;
    } spfs_cmd_t;

    typedef struct packed {
        logic any_ready;
        logic push_ok;
    } spfs_status_t;

    typedef enum logic [1:0] {
        ST_IDLE    = 2'd0,
        ST_REQUEUE = 2'd1,
        ST_HOLD    = 2'd2
    } spfs_state_t;

endpackage

`default_nettype wire

>>> hw/rtl/spfs_ram.sv
// ----------------------------------------------------------------------------
// spfs_ram
// generic simple dual port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfs_ram #(
    parameter int  WIDTH  = 8,
    parameter int  DEPTH  = 48,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              aclk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/spfs_level_ctrl.sv
// ----------------------------------------------------------------------------
// spfs_level_ctrl
// per level head, tail and count registers, level search and queue memory
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfs_level_ctrl #(
    parameter int LEVELS      = 3,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire spfs_pkg::spfs_cmd_t  cmd,
    input  wire logic [ID_BITS-1:0]   push_id,
    output spfs_pkg::spfs_status_t    status,
    output logic      [ID_BITS-1:0]   pop_id
);

    localparam int LVL_W  = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int STORE  = LEVELS * QUEUE_DEPTH;
    localparam int ADDR_W = $clog2(STORE);

    logic [CNT_W-1:0]  counts_reg [LEVELS];
    logic [CNT_W-1:0]  counts_next [LEVELS];
    logic [SLOT_W-1:0] heads_reg [LEVELS];
    logic [SLOT_W-1:0] heads_next [LEVELS];
    logic [SLOT_W-1:0] tails_reg [LEVELS];
    logic [SLOT_W-1:0] tails_next [LEVELS];

    logic              any_ready;
    logic [LVL_W-1:0]  found_lv;
    logic              in_range;
    logic [LVL_W-1:0]  push_lv;
    logic              push_ok;
    logic              push_fire;
    logic              pop_fire;
    logic [ADDR_W-1:0] push_addr;
    logic [ADDR_W-1:0] pop_addr;

    function automatic logic [SLOT_W-1:0] slot_advance(input logic [SLOT_W-1:0] slot);
        logic [SLOT_W-1:0] nxt;
        nxt = (slot == SLOT_W'(QUEUE_DEPTH - 1)) ? '0 : slot + 1'b1;
        return nxt;
    endfunction

    // highest non-empty level wins
    always_comb begin
        any_ready = 1'b0;
        found_lv  = '0;
        for (int lv = 0; lv < LEVELS; lv++) begin
            if (counts_reg[lv] != '0) begin
                any_ready = 1'b1;
                found_lv  = LVL_W'(lv);
            end
        end
    end

    assign in_range  = (int'(cmd.push_prio) < LEVELS);
    assign push_lv   = LVL_W'(cmd.push_prio);
    assign push_ok   = in_range && (counts_reg[push_lv] != CNT_W'(QUEUE_DEPTH));
    assign push_fire = cmd.push_en && push_ok;
    assign pop_fire  = cmd.pop_en && any_ready;

    assign push_addr = ADDR_W'(int'(push_lv) * QUEUE_DEPTH) + ADDR_W'(tails_reg[push_lv]);
    assign pop_addr  = ADDR_W'(int'(found_lv) * QUEUE_DEPTH) + ADDR_W'(heads_reg[found_lv]);

    assign status.any_ready = any_ready;
    assign status.push_ok   = push_ok;

    always_comb begin
        for (int lv = 0; lv < LEVELS; lv++) begin
            counts_next[lv] = counts_reg[lv];
            heads_next[lv]  = heads_reg[lv];
            tails_next[lv]  = tails_reg[lv];
            if (push_fire && (push_lv == LVL_W'(lv))) begin
                counts_next[lv] = counts_next[lv] + 1'b1;
                tails_next[lv]  = slot_advance(tails_reg[lv]);
            end
            if (pop_fire && (found_lv == LVL_W'(lv))) begin
                counts_next[lv] = counts_next[lv] - 1'b1;
                heads_next[lv]  = slot_advance(heads_reg[lv]);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int lv = 0; lv < LEVELS; lv++) begin
                counts_reg[lv] <= '0;
                heads_reg[lv]  <= '0;
                tails_reg[lv]  <= '0;
            end
        end else begin
            for (int lv = 0; lv < LEVELS; lv++) begin
                counts_reg[lv] <= counts_next[lv];
                heads_reg[lv]  <= heads_next[lv];
                tails_reg[lv]  <= tails_next[lv];
            end
        end
    end

    spfs_ram #(
        .WIDTH (ID_BITS),
        .DEPTH (STORE)
    ) u_store (
        .aclk  (aclk),
        .we    (push_fire),
        .waddr (push_addr),
        .wdata (push_id),
        .re    (pop_fire),
        .raddr (pop_addr),
        .rdata (pop_id)
    );

endmodule

`default_nettype wire

>>> hw/rtl/strict_priority_fifo_scheduler_core.sv
// ----------------------------------------------------------------------------
// strict_priority_fifo_scheduler_core
// strict priority scheduler with one thread id fifo per level in a shared ram
// ----------------------------------------------------------------------------
// result path: a create, or a schedule that finds every level empty, is answered
//   from the idle state; a schedule that picks a thread first reads the queue ram
//   through its registered read port and answers from the requeue state
// flow: one item in flight at a time
// reset: synchronous, clears level pointers, counts and handshake state;
//   the queue ram is not cleared and needs no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module strict_priority_fifo_scheduler_core #(
    parameter int LEVELS      = 3,
    parameter int QUEUE_DEPTH = 16,
    parameter int ID_BITS     = 8
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire spfs_pkg::spfs_in_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output spfs_pkg::spfs_out_t      m_data
);

    spfs_pkg::spfs_state_t  state_reg;
    spfs_pkg::spfs_state_t  state_next;
    spfs_pkg::spfs_in_t     req_reg;
    spfs_pkg::spfs_out_t    res_reg;
    spfs_pkg::spfs_out_t    m_data_reg;
    logic                   m_valid_reg;

    spfs_pkg::spfs_cmd_t    cmd;
    spfs_pkg::spfs_status_t status;
    spfs_pkg::spfs_out_t    imm_result;
    logic                   imm_done;
    logic                   s_accept;
    logic                   out_free;
    logic [ID_BITS-1:0]     push_id;
    logic [ID_BITS-1:0]     pop_id;
    logic [ID_BITS-1:0]     in_id;
    logic [ID_BITS-1:0]     req_id;

    assign s_accept = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign in_id    = ID_MAX_W_sel(s_data.thread_id);
    assign req_id   = ID_MAX_W_sel(req_reg.thread_id);

    function automatic logic [ID_BITS-1:0] ID_MAX_W_sel(
        input logic [spfs_pkg::THREAD_ID_W-1:0] id
    );
        logic [spfs_pkg::ID_MAX_W-1:0] wide;
        wide = spfs_pkg::ID_MAX_W'(id);
        return wide[ID_BITS-1:0];
    endfunction

    function automatic logic [spfs_pkg::THREAD_ID_W-1:0] id_out(input logic [ID_BITS-1:0] id);
        logic [spfs_pkg::ID_MAX_W-1:0] wide;
        wide = spfs_pkg::ID_MAX_W'(id);
        return wide[spfs_pkg::THREAD_ID_W-1:0];
    endfunction

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            spfs_pkg::ST_IDLE: begin
                if (s_accept) begin
                    if (!imm_done) begin
                        state_next = spfs_pkg::ST_REQUEUE;
                    end else if (!out_free) begin
                        state_next = spfs_pkg::ST_HOLD;
                    end
                end
            end
            spfs_pkg::ST_REQUEUE: begin
                state_next = out_free ? spfs_pkg::ST_IDLE : spfs_pkg::ST_HOLD;
            end
            spfs_pkg::ST_HOLD: begin
                if (out_free) begin
                    state_next = spfs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = spfs_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs and queue commands
    always_comb begin
        s_ready       = 1'b0;
        cmd.push_en   = 1'b0;
        cmd.pop_en    = 1'b0;
        cmd.push_prio = s_data.thread_prio;
        push_id       = in_id;
        imm_done      = 1'b0;
        imm_result    = '0;
        case (state_reg)
            spfs_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_data.req_type == spfs_pkg::REQ_CREATE) begin
                    cmd.push_en         = s_valid;
                    imm_done            = s_valid;
                    imm_result.overflow = !status.push_ok;
                end else begin
                    cmd.pop_en = s_valid;
                    if (!status.any_ready) begin
                        imm_done = s_valid;
                        if (s_data.current_valid) begin
                            imm_result.next_id = id_out(in_id);
                        end
                    end
                end
            end
            spfs_pkg::ST_REQUEUE: begin
                cmd.push_en            = req_reg.current_valid;
                cmd.push_prio          = req_reg.thread_prio;
                push_id                = req_id;
                imm_done               = 1'b1;
                imm_result.next_valid  = 1'b1;
                imm_result.next_id     = id_out(pop_id);
                if (req_reg.current_valid) begin
                    imm_result.switch_kind = spfs_pkg::KIND_SWAP;
                    imm_result.overflow    = !status.push_ok;
                end else begin
                    imm_result.switch_kind = spfs_pkg::KIND_SET;
                end
            end
            spfs_pkg::ST_HOLD: begin
                imm_done = 1'b0;
            end
            default: begin
                imm_done = 1'b0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= spfs_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (imm_done && out_free) begin
                m_valid_reg <= 1'b1;
            end else if ((state_reg == spfs_pkg::ST_HOLD) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            req_reg <= s_data;
        end
        if (imm_done) begin
            res_reg <= imm_result;
        end
        if (imm_done && out_free) begin
            m_data_reg <= imm_result;
        end else if ((state_reg == spfs_pkg::ST_HOLD) && out_free) begin
            m_data_reg <= res_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    spfs_level_ctrl #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) u_level_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .push_id (push_id),
        .status  (status),
        .pop_id  (pop_id)
    );

endmodule

`default_nettype wire

>>> hw/rtl/spfs_checker.sv
// ----------------------------------------------------------------------------
// spfs_checker
// port level checks for the strict priority fifo scheduler
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module spfs_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_valid,
    input wire logic                s_ready,
    input wire spfs_pkg::spfs_in_t  s_data,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire spfs_pkg::spfs_out_t m_data
);

    // stalled result item holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // a picked thread is always reported as swap or set
    a_pick_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.next_valid |->
            (m_data.switch_kind == spfs_pkg::KIND_SWAP) ||
            (m_data.switch_kind == spfs_pkg::KIND_SET))
        else $error("picked thread with keep kind");

    // no picked thread means keep kind
    a_keep_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.next_valid |-> m_data.switch_kind == spfs_pkg::KIND_KEEP)
        else $error("kind set without a picked thread");

    // a set never appends
    a_set_no_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.switch_kind == spfs_pkg::KIND_SET) |-> !m_data.overflow)
        else $error("overflow reported on set");

endmodule

bind strict_priority_fifo_scheduler_core spfs_checker u_spfs_checker (.*);

`default_nettype wire

>>> tb/sv/strict_priority_fifo_scheduler_core_tb.sv
// ----------------------------------------------------------------------------
// strict_priority_fifo_scheduler_core_tb
// drives create and schedule items through the scheduler with random gaps on
// both channels; a small scoreboard keeps its own per level thread fifos,
// predicts every decision and checks each result field by field in order
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module strict_priority_fifo_scheduler_core_tb;

    localparam int LEVELS      = 3;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int RANDOM_ITEMS = 900;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int TAIL_CYCLES  = 4;
    localparam logic [spfs_pkg::THREAD_ID_W-1:0] ID_MASK =
        spfs_pkg::THREAD_ID_W'((1 << ID_BITS) - 1);
    localparam logic [spfs_pkg::PRIO_W-1:0] PRIO_BAD = 2'd3;

    class sched_decision_board;
        logic [spfs_pkg::THREAD_ID_W-1:0] slot_ids [LEVELS*QUEUE_DEPTH];
        int                  heads [LEVELS];
        int                  tails [LEVELS];
        int                  counts [LEVELS];
        spfs_pkg::spfs_out_t expected_q [$];
        int                  failures;

        function new();
            foreach (heads[i]) begin
                heads[i]  = 0;
                tails[i]  = 0;
                counts[i] = 0;
            end
            failures = 0;
        endfunction

        function bit append_thread(logic [spfs_pkg::PRIO_W-1:0] lvl,
                                   logic [spfs_pkg::THREAD_ID_W-1:0] id);
            if (lvl >= LEVELS) return 1'b0;
            if (counts[lvl] >= QUEUE_DEPTH) return 1'b0;
            slot_ids[lvl*QUEUE_DEPTH + tails[lvl]] = id;
            tails[lvl] = (tails[lvl] + 1 >= QUEUE_DEPTH) ? 0 : tails[lvl] + 1;
            counts[lvl]++;
            return 1'b1;
        endfunction

        function logic [spfs_pkg::THREAD_ID_W-1:0] take_head(int lvl);
            logic [spfs_pkg::THREAD_ID_W-1:0] id;
            id = slot_ids[lvl*QUEUE_DEPTH + heads[lvl]];
            heads[lvl] = (heads[lvl] + 1 >= QUEUE_DEPTH) ? 0 : heads[lvl] + 1;
            counts[lvl]--;
            return id;
        endfunction

        function void note_request(spfs_pkg::spfs_in_t req);
            spfs_pkg::spfs_out_t              d;
            int                               found;
            logic [spfs_pkg::THREAD_ID_W-1:0] id;
            d     = '0;
            found = -1;
            id    = req.thread_id & ID_MASK;
            if (req.req_type == spfs_pkg::REQ_CREATE) begin
                d.overflow = !append_thread(req.thread_prio, id);
            end else begin
                for (int lv = LEVELS - 1; lv >= 0; lv--) begin
                    if (found < 0 && counts[lv] != 0) found = lv;
                end
                if (found >= 0) begin
                    d.next_valid = 1'b1;
                    d.next_id    = take_head(found);
                    if (req.current_valid) begin
                        d.switch_kind = spfs_pkg::KIND_SWAP;
                        // re-queue goes in after the pop so a freed slot can take it
                        d.overflow    = !append_thread(req.thread_prio, id);
                    end else begin
                        d.switch_kind = spfs_pkg::KIND_SET;
                    end
                end else begin
                    d.switch_kind = spfs_pkg::KIND_KEEP;
                    d.next_id     = req.current_valid ? id : '0;
                end
            end
            expected_q.push_back(d);
        endfunction

        function void flag(string msg);
            failures++;
            if (failures <= 10) $display("%s", msg);
        endfunction

        function void check_decision(spfs_pkg::spfs_out_t got);
            spfs_pkg::spfs_out_t exp;
            if (expected_q.size() == 0) begin
                flag($sformatf("unexpected result: valid=%0d id=%02h kind=%0d ovf=%0d",
                               got.next_valid, got.next_id, got.switch_kind, got.overflow));
                return;
            end
            exp = expected_q.pop_front();
            if (got.next_valid !== exp.next_valid || got.next_id !== exp.next_id ||
                got.switch_kind !== exp.switch_kind || got.overflow !== exp.overflow) begin
                flag($sformatf({"mismatch: expected valid=%0d id=%02h kind=%0d ovf=%0d,",
                                " got valid=%0d id=%02h kind=%0d ovf=%0d"},
                               exp.next_valid, exp.next_id, exp.switch_kind, exp.overflow,
                               got.next_valid, got.next_id, got.switch_kind, got.overflow));
            end
        endfunction
    endclass

    logic                aclk    = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    spfs_pkg::spfs_in_t  s_data  = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    spfs_pkg::spfs_out_t m_data;

    sched_decision_board decisions = new();
    bit          steady_run = 1'b0;
    int          rx_stall   = 0;
    int unsigned cycle_count = 0;

    strict_priority_fifo_scheduler_core #(
        .LEVELS      (LEVELS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .ID_BITS     (ID_BITS)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady_run || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // accepted items and results, sampled at the edge that moves them
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) decisions.note_request(s_data);
            if (m_valid && m_ready) decisions.check_decision(m_data);
        end
    end

    always @(posedge aclk) begin : rx_side
        int next_stall;
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_ready  <= (rx_stall == 1);
        end else if (aresetn && m_valid && m_ready) begin
            next_stall = pick_gap();
            rx_stall   <= next_stall;
            m_ready    <= (next_stall == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic send_req(logic rt, logic [7:0] id, logic [1:0] prio, logic cur);
        spfs_pkg::spfs_in_t req;
        int                 gap;
        req.req_type      = rt;
        req.thread_id     = id;
        req.thread_prio   = prio;
        req.current_valid = cur;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (decisions.expected_q.size() != 0);
    endtask

    task automatic send_random(int create_pct);
        logic       rt;
        logic [1:0] prio;
        rt   = ($urandom_range(0, 99) < create_pct) ? spfs_pkg::REQ_CREATE
                                                    : spfs_pkg::REQ_SCHEDULE;
        prio = ($urandom_range(0, 99) < 8) ? PRIO_BAD : 2'($urandom_range(0, LEVELS - 1));
        send_req(rt, 8'($urandom_range(0, 255)), prio, 1'($urandom_range(0, 1)));
    endtask

    initial begin
        int sent;
        int block_len;
        int create_pct;
        sent = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // empty scheduler, with and without a running thread
        send_req(spfs_pkg::REQ_SCHEDULE, 8'h3c, 2'd0, 1'b0);
        send_req(spfs_pkg::REQ_SCHEDULE, 8'hff, 2'd2, 1'b1);
        // level out of range
        send_req(spfs_pkg::REQ_CREATE, 8'h00, PRIO_BAD, 1'b1);
        send_req(spfs_pkg::REQ_CREATE, 8'hff, 2'd0, 1'b0);
        send_req(spfs_pkg::REQ_CREATE, 8'h01, 2'd1, 1'b1);
        send_req(spfs_pkg::REQ_CREATE, 8'h80, 2'd2, 1'b0);
        send_req(spfs_pkg::REQ_CREATE, 8'h7f, 2'd2, 1'b1);
        // swap, set, swap with bad re-queue level, swap from the lowest level
        send_req(spfs_pkg::REQ_SCHEDULE, 8'h11, 2'd0, 1'b1);
        send_req(spfs_pkg::REQ_SCHEDULE, 8'h55, 2'd1, 1'b0);
        send_req(spfs_pkg::REQ_SCHEDULE, 8'h22, PRIO_BAD, 1'b1);
        send_req(spfs_pkg::REQ_SCHEDULE, 8'h33, 2'd1, 1'b1);
        // fill the top level past full, then re-queue into the freed slot
        for (int i = 0; i <= QUEUE_DEPTH; i++) begin
            send_req(spfs_pkg::REQ_CREATE, 8'(8'hc0 + i), 2'd2, 1'b0);
        end
        send_req(spfs_pkg::REQ_SCHEDULE, 8'haa, 2'd2, 1'b1);
        wait_drained();

        while (sent < RANDOM_ITEMS) begin
            block_len  = $urandom_range(20, 60);
            steady_run = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 2))
                0: create_pct = 85;
                1: create_pct = 50;
                default: create_pct = 15;
            endcase
            if ($urandom_range(0, 3) == 0) wait_drained();
            for (int i = 0; i < block_len && sent < RANDOM_ITEMS; i++) begin
                send_random(create_pct);
                sent++;
            end
        end
        steady_run = 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (decisions.failures == 0 && decisions.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
